@@ rtl/emfc_pkg.sv @@
// ----------------------------------------------------------------------------
// emfc_pkg
// Shared types, constants and helper functions of the frame checker.
// ----------------------------------------------------------------------------
package emfc_pkg;

    localparam int CNT_W = 14;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam int MIN_TOTAL = 32;
    localparam int LEN_OVERHEAD = 12;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRLF = 16'h0D0A;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_FRAME     = 3'd1;
    localparam logic [2:0] ERR_DIGITS    = 3'd2;
    localparam logic [2:0] ERR_LENGTH    = 3'd3;
    localparam logic [2:0] ERR_FIELDS    = 3'd4;
    localparam logic [2:0] ERR_CRC_CHARS = 3'd5;
    localparam logic [2:0] ERR_CRC       = 3'd6;

    localparam logic [2:0] CN_LEN = 3'd4;
    localparam logic [3:0] CP_LEN = 4'd15;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } byte_item_t;

    typedef struct packed {
        logic        frame_ok;
        logic [2:0]  error_code;
        logic [15:0] computed_crc;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // {not_hex, nibble}; a non-hex character yields nibble 4'hF
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        if (b >= "0" && b <= "9") begin
            r = {1'b0, 4'(b - 8'h30)};
        end
        else if (b >= "a" && b <= "f") begin
            r = {1'b0, 4'(b - 8'h57)};
        end
        else if (b >= "A" && b <= "F") begin
            r = {1'b0, 4'(b - 8'h37)};
        end
        else begin
            r = 5'h1F;
        end
        return r;
    endfunction

    function automatic logic [7:0] qn_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = "Q";
            2'd1:    c = "N";
            default: c = "=";
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cn_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = ";";
            2'd1:    c = "C";
            2'd2:    c = "N";
            default: c = "=";
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cp_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = ";";
            4'd1:    c = "C";
            4'd2:    c = "P";
            4'd3:    c = "=";
            4'd4:    c = "&";
            4'd5:    c = "&";
            4'd6:    c = "D";
            4'd7:    c = "a";
            4'd8:    c = "t";
            4'd9:    c = "a";
            4'd10:   c = "T";
            4'd11:   c = "i";
            4'd12:   c = "m";
            4'd13:   c = "e";
            default: c = "=";
        endcase
        return c;
    endfunction

endpackage

@@ rtl/emfc_if.sv @@
// ----------------------------------------------------------------------------
// emfc_if
// Valid/ready channels of the frame checker: byte input and result output.
// ----------------------------------------------------------------------------
interface emfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface emfc_result_if;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    logic [2:0]  error_code;
    logic [15:0] computed_crc;

    modport source (output valid, output frame_ok, output error_code, output computed_crc,
                    input ready);
    modport sink (input valid, input frame_ok, input error_code, input computed_crc,
                  output ready);
endinterface

@@ rtl/emfc_in_reg.sv @@
// ----------------------------------------------------------------------------
// emfc_in_reg
// Input register: holds one byte transaction until the checker core takes it.
// ----------------------------------------------------------------------------
module emfc_in_reg
    import emfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  byte_item_t in_item,
    output logic       in_ready,
    input  logic       advance,
    output logic       held_valid,
    output byte_item_t held_item
);

    logic       vld_reg;
    byte_item_t item_reg;

    assign in_ready   = !vld_reg || advance;
    assign held_valid = vld_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ rtl/emfc_check_core.sv @@
// ----------------------------------------------------------------------------
// emfc_check_core
// Per-frame state: position, length, CRC, field matchers and check flags.
// Produces the verdict on the closing byte and returns to reset state.
// ----------------------------------------------------------------------------
module emfc_check_core
    import emfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  byte_item_t item,
    output logic       res_valid,
    output result_t    res
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      rx_crc_reg, rx_crc_next;
    logic [15:0]      last2_reg, last2_next;
    logic             start_fail_reg, start_fail_next;
    logic             digit_fail_reg, digit_fail_next;
    logic             qn_fail_reg, qn_fail_next;
    logic             end_fail_reg, end_fail_next;
    logic             hex_fail_reg, hex_fail_next;
    logic             cn_found_reg, cn_found_next;
    logic             cp_found_reg, cp_found_next;
    logic [1:0]       cn_pos_reg, cn_pos_next;
    logic [3:0]       cp_pos_reg, cp_pos_next;

    logic [7:0]       b;
    logic [CNT_W:0]   pos_w;
    logic [CNT_W:0]   len_w;
    logic [CNT_W-1:0] ci;
    logic [2:0]       cn_step;
    logic [4:0]       cp_step;
    logic [4:0]       hx;
    logic [CNT_W:0]   total_w;
    logic [2:0]       err;

    always_comb
    begin
        b     = item.data_byte;
        pos_w = {1'b0, count_reg};
        len_w = {1'b0, len_reg};
        ci    = count_reg - CNT_W'(6);
        hx    = hex_decode(b);

        count_next      = count_reg;
        len_next        = len_reg;
        crc_next        = crc_reg;
        rx_crc_next     = rx_crc_reg;
        start_fail_next = start_fail_reg;
        digit_fail_next = digit_fail_reg;
        qn_fail_next    = qn_fail_reg;
        end_fail_next   = end_fail_reg;
        hex_fail_next   = hex_fail_reg;
        cn_found_next   = cn_found_reg;
        cp_found_next   = cp_found_reg;
        cn_pos_next     = cn_pos_reg;
        cp_pos_next     = cp_pos_reg;
        cn_step         = 3'd0;
        cp_step         = 5'd0;

        if (count_reg < CNT_W'(2))
        begin
            if (b != "#")
            begin
                start_fail_next = 1'b1;
            end
        end
        else if (count_reg < CNT_W'(6))
        begin
            if (b < "0" || b > "9")
            begin
                digit_fail_next = 1'b1;
            end
            len_next = CNT_W'(len_reg * CNT_W'(10)) + CNT_W'(b) - CNT_W'(48);
        end
        else if (pos_w < len_w + (CNT_W+1)'(6))
        begin
            crc_next = crc16_byte(crc_reg, b);
            if (count_reg < CNT_W'(9) && b != qn_char(ci[1:0]))
            begin
                qn_fail_next = 1'b1;
            end
            if (pos_w >= len_w + (CNT_W+1)'(4) && b != "&")
            begin
                end_fail_next = 1'b1;
            end
            if (!cn_found_reg)
            begin
                if (b == cn_char(cn_pos_reg))
                begin
                    cn_step = {1'b0, cn_pos_reg} + 3'd1;
                end
                else
                begin
                    cn_step = (b == ";") ? 3'd1 : 3'd0;
                end
                if (cn_step >= CN_LEN)
                begin
                    cn_found_next = 1'b1;
                    cn_pos_next   = 2'd0;
                end
                else
                begin
                    cn_pos_next = cn_step[1:0];
                end
            end
            if (!cp_found_reg)
            begin
                if (b == cp_char(cp_pos_reg))
                begin
                    cp_step = {1'b0, cp_pos_reg} + 5'd1;
                end
                else
                begin
                    cp_step = (b == ";") ? 5'd1 : 5'd0;
                end
                if (cp_step >= {1'b0, CP_LEN})
                begin
                    cp_found_next = 1'b1;
                    cp_pos_next   = 4'd0;
                end
                else
                begin
                    cp_pos_next = cp_step[3:0];
                end
            end
        end
        else if (pos_w < len_w + (CNT_W+1)'(10))
        begin
            if (hx[4])
            begin
                hex_fail_next = 1'b1;
            end
            rx_crc_next = {rx_crc_reg[11:0], hx[3:0]};
        end

        last2_next = {last2_reg[7:0], b};
        if (count_reg != CNT_MAX)
        begin
            count_next = count_reg + CNT_W'(1);
        end

        total_w = {1'b0, count_next};
        if (count_next < CNT_W'(MIN_TOTAL) || start_fail_next || last2_next != CRLF)
        begin
            err = ERR_FRAME;
        end
        else if (digit_fail_next)
        begin
            err = ERR_DIGITS;
        end
        else if (len_next == '0 ||
                 total_w != {1'b0, len_next} + (CNT_W+1)'(LEN_OVERHEAD))
        begin
            err = ERR_LENGTH;
        end
        else if (qn_fail_next || end_fail_next || !cn_found_next || !cp_found_next)
        begin
            err = ERR_FIELDS;
        end
        else if (hex_fail_next)
        begin
            err = ERR_CRC_CHARS;
        end
        else if (crc_next != rx_crc_next)
        begin
            err = ERR_CRC;
        end
        else
        begin
            err = ERR_OK;
        end
    end

    assign res_valid        = advance && item.frame_end;
    assign res.frame_ok     = (err == ERR_OK);
    assign res.error_code   = err;
    assign res.computed_crc = crc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            len_reg        <= '0;
            crc_reg        <= CRC_INIT;
            rx_crc_reg     <= '0;
            last2_reg      <= '0;
            start_fail_reg <= 1'b0;
            digit_fail_reg <= 1'b0;
            qn_fail_reg    <= 1'b0;
            end_fail_reg   <= 1'b0;
            hex_fail_reg   <= 1'b0;
            cn_found_reg   <= 1'b0;
            cp_found_reg   <= 1'b0;
            cn_pos_reg     <= '0;
            cp_pos_reg     <= '0;
        end
        else if (advance)
        begin
            if (item.frame_end)
            begin
                count_reg      <= '0;
                len_reg        <= '0;
                crc_reg        <= CRC_INIT;
                rx_crc_reg     <= '0;
                last2_reg      <= '0;
                start_fail_reg <= 1'b0;
                digit_fail_reg <= 1'b0;
                qn_fail_reg    <= 1'b0;
                end_fail_reg   <= 1'b0;
                hex_fail_reg   <= 1'b0;
                cn_found_reg   <= 1'b0;
                cp_found_reg   <= 1'b0;
                cn_pos_reg     <= '0;
                cp_pos_reg     <= '0;
            end
            else
            begin
                count_reg      <= count_next;
                len_reg        <= len_next;
                crc_reg        <= crc_next;
                rx_crc_reg     <= rx_crc_next;
                last2_reg      <= last2_next;
                start_fail_reg <= start_fail_next;
                digit_fail_reg <= digit_fail_next;
                qn_fail_reg    <= qn_fail_next;
                end_fail_reg   <= end_fail_next;
                hex_fail_reg   <= hex_fail_next;
                cn_found_reg   <= cn_found_next;
                cp_found_reg   <= cp_found_next;
                cn_pos_reg     <= cn_pos_next;
                cp_pos_reg     <= cp_pos_next;
            end
        end
    end

endmodule

@@ rtl/env_monitor_frame_checker_unit.sv @@
// ----------------------------------------------------------------------------
// env_monitor_frame_checker_unit
// Byte-stream checker for environmental-monitoring frames with CRC-16.
//
// frame_in carries one frame byte per transaction; frame_end marks the last
// byte. result_out carries one transaction per frame: frame_ok, the first
// failing check as error_code, and the CRC-16 over the content bytes.
// A byte is registered on acceptance in the input register and processed
// from there by the checker core; the verdict of a closing byte is
// registered in the output register, which drives result_out.valid, and
// is held there until result_out.ready takes it.
// Throughput is one byte per cycle (unless a closing byte waits on a held
// result), set by the combinational CRC and field matchers in the core.
// If result_out stalls, the next frame's bytes are still taken until a
// second closing byte reaches the core; frame_in.ready then drops until
// the held result is taken.
// Reset clears the frame state, the CRC to 0xFFFF and both valid flags.
// ----------------------------------------------------------------------------
module env_monitor_frame_checker_unit
    import emfc_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    emfc_byte_if.sink      frame_in,
    emfc_result_if.source  result_out
);

    byte_item_t in_item;
    byte_item_t held_item;
    logic       held_valid;
    logic       advance;
    logic       res_valid;
    result_t    res;
    logic       out_vld_reg;
    result_t    out_reg;

    assign in_item.data_byte = frame_in.data_byte;
    assign in_item.frame_end = frame_in.frame_end;

    assign advance = held_valid && (!held_item.frame_end || !out_vld_reg || result_out.ready);

    emfc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (frame_in.valid),
        .in_item    (in_item),
        .in_ready   (frame_in.ready),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    emfc_check_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (held_item),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign result_out.valid        = out_vld_reg;
    assign result_out.frame_ok     = out_reg.frame_ok;
    assign result_out.error_code   = out_reg.error_code;
    assign result_out.computed_crc = out_reg.computed_crc;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for env_monitor_frame_checker_unit. Frames are sent
// byte by byte: a directed set for each check and corner, then random
// well-formed frames, corrupted frames and noise. A frame predictor tracks
// the header, content fields, CRC-16 and trailer of every accepted byte;
// each result transaction is compared with the oldest predicted verdict.
// ----------------------------------------------------------------------------
package emfc_tb_pkg;
    import emfc_pkg::*;

    localparam string QN_TAG = "QN=";
    localparam string CN_TAG = ";CN=";
    localparam string CP_TAG = ";CP=&&DataTime=";

    function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic int hex_value(logic [7:0] b);
        if (b >= "0" && b <= "9")
        begin
            return int'(b) - 48;
        end
        if (b >= "a" && b <= "f")
        begin
            return int'(b) - 87;
        end
        if (b >= "A" && b <= "F")
        begin
            return int'(b) - 55;
        end
        return -1;
    endfunction

    class frame_verdict_board;
        logic [13:0] seen_bytes;
        logic [13:0] decl_len;
        logic [15:0] crc_acc;
        logic [15:0] rx_crc;
        logic [15:0] tail;
        bit          start_bad;
        bit          digit_bad;
        bit          qn_bad;
        bit          end_bad;
        bit          hex_bad;
        bit          cn_found;
        bit          cp_found;
        int          cn_pos;
        int          cp_pos;
        result_t     verdicts[$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            seen_bytes = '0;
            decl_len = '0;
            crc_acc = CRC_INIT;
            rx_crc = '0;
            tail = '0;
            start_bad = 0;
            digit_bad = 0;
            qn_bad = 0;
            end_bad = 0;
            hex_bad = 0;
            cn_found = 0;
            cp_found = 0;
            cn_pos = 0;
            cp_pos = 0;
        endfunction

        // ';' occurs only at the head of both tags, so a miss restarts at 0 or 1
        function int match_next(int pos, logic [7:0] b, string tag);
            if (b == tag[pos])
            begin
                return pos + 1;
            end
            return (b == ";") ? 1 : 0;
        endfunction

        function void note_byte(logic [7:0] b, logic is_last);
            int          pos;
            int          len;
            int          ci;
            int          h;
            logic [31:0] acc;
            result_t     v;
            pos = seen_bytes;
            len = decl_len;
            if (pos < 2)
            begin
                if (b != "#") start_bad = 1;
            end
            else if (pos < 6)
            begin
                if (b < "0" || b > "9") digit_bad = 1;
                acc = 32'(decl_len) * 32'd10 + 32'(b) - 32'd48;
                decl_len = acc[13:0];
            end
            else if (pos < 6 + len)
            begin
                ci = pos - 6;
                crc_acc = crc16_next(crc_acc, b);
                if (ci < 3 && b != QN_TAG[ci]) qn_bad = 1;
                if (ci + 2 >= len && b != "&") end_bad = 1;
                if (!cn_found)
                begin
                    cn_pos = match_next(cn_pos, b, CN_TAG);
                    if (cn_pos >= int'(CN_LEN))
                    begin
                        cn_found = 1;
                        cn_pos = 0;
                    end
                end
                if (!cp_found)
                begin
                    cp_pos = match_next(cp_pos, b, CP_TAG);
                    if (cp_pos >= int'(CP_LEN))
                    begin
                        cp_found = 1;
                        cp_pos = 0;
                    end
                end
            end
            else if (pos < 10 + len)
            begin
                h = hex_value(b);
                if (h < 0) hex_bad = 1;
                rx_crc = {rx_crc[11:0], 4'(h)};
            end
            tail = {tail[7:0], b};
            if (seen_bytes != CNT_MAX) seen_bytes++;
            if (!is_last) return;

            v.computed_crc = crc_acc;
            if (seen_bytes < MIN_TOTAL || start_bad || tail != CRLF)
                v.error_code = ERR_FRAME;
            else if (digit_bad)
                v.error_code = ERR_DIGITS;
            else if (decl_len == 0 || int'(seen_bytes) != int'(decl_len) + LEN_OVERHEAD)
                v.error_code = ERR_LENGTH;
            else if (qn_bad || end_bad || !cn_found || !cp_found)
                v.error_code = ERR_FIELDS;
            else if (hex_bad)
                v.error_code = ERR_CRC_CHARS;
            else if (crc_acc != rx_crc)
                v.error_code = ERR_CRC;
            else
                v.error_code = ERR_OK;
            v.frame_ok = (v.error_code == ERR_OK);
            verdicts.push_back(v);
            restart();
        endfunction

        function void check_verdict(logic ok, logic [2:0] code, logic [15:0] crc);
            result_t exp;
            if (verdicts.size() == 0)
            begin
                $display("%0t: unexpected result ok=%0b err=%0d crc=%h", $time, ok, code, crc);
                errors++;
                return;
            end
            exp = verdicts.pop_front();
            if (ok !== exp.frame_ok)
            begin
                $display("%0t: frame_ok expected %0b actual %0b", $time, exp.frame_ok, ok);
                errors++;
            end
            if (code !== exp.error_code)
            begin
                $display("%0t: error_code expected %0d actual %0d", $time, exp.error_code,
                         code);
                errors++;
            end
            if (crc !== exp.computed_crc)
            begin
                $display("%0t: computed_crc expected %h actual %h", $time, exp.computed_crc,
                         crc);
                errors++;
            end
        endfunction
    endclass
endpackage

module tb;
    import emfc_pkg::*;
    import emfc_tb_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    emfc_byte_if   byte_ch();
    emfc_result_if res_ch();

    env_monitor_frame_checker_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (byte_ch),
        .result_out (res_ch)
    );

    frame_verdict_board sb = new();

    logic [7:0] body[$];
    logic [7:0] frame_bytes[$];
    int         src_idle_pct = 0;
    int         snk_idle_pct = 0;
    int         sent_items = 0;

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        res_ch.ready = ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            sb.check_verdict(res_ch.frame_ok, res_ch.error_code, res_ch.computed_crc);
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) body.push_back(s[i]);
    endfunction

    function automatic void add_fill(int n, bit wild);
        for (int i = 0; i < n; i++)
        begin
            body.push_back(wild ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126)));
        end
    endfunction

    function automatic void make_body(int fill_max, bit wild);
        body.delete();
        add_text(QN_TAG);
        add_fill($urandom_range(0, fill_max), wild);
        if ($urandom_range(0, 1))
        begin
            add_text(CN_TAG);
            add_fill($urandom_range(0, fill_max), wild);
            add_text(CP_TAG);
        end
        else
        begin
            add_text(CP_TAG);
            add_fill($urandom_range(0, fill_max), wild);
            add_text(CN_TAG);
        end
        add_fill($urandom_range(0, fill_max), wild);
        add_text("&&");
    endfunction

    // header, content, CRC characters (high nibble first), CR LF
    function automatic void wrap_body(bit upper);
        logic [15:0] crc;
        logic [3:0]  nib;
        int          n;
        n = body.size();
        crc = CRC_INIT;
        frame_bytes.delete();
        frame_bytes.push_back("#");
        frame_bytes.push_back("#");
        frame_bytes.push_back(8'(48 + (n / 1000) % 10));
        frame_bytes.push_back(8'(48 + (n / 100) % 10));
        frame_bytes.push_back(8'(48 + (n / 10) % 10));
        frame_bytes.push_back(8'(48 + n % 10));
        foreach (body[i])
        begin
            frame_bytes.push_back(body[i]);
            crc = crc16_next(crc, body[i]);
        end
        for (int k = 3; k >= 0; k--)
        begin
            nib = crc[4*k +: 4];
            frame_bytes.push_back(nib < 10 ? 8'(48 + nib) : 8'((upper ? 55 : 87) + nib));
        end
        frame_bytes.push_back(8'h0D);
        frame_bytes.push_back(8'h0A);
    endfunction

    task automatic drive_byte(logic [7:0] b, logic is_last);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            byte_ch.valid = 1'b0;
            @(negedge clk);
        end
        byte_ch.valid = 1'b1;
        byte_ch.data_byte = b;
        byte_ch.frame_end = is_last;
        do @(posedge clk); while (byte_ch.ready !== 1'b1);
        sb.note_byte(b, is_last);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            drive_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    task automatic wait_drained();
        byte_ch.valid = 1'b0;
        while (sb.verdicts.size() != 0) @(negedge clk);
    endtask

    initial
    begin
        int kind;
        int n;
        int rnd_frames;

        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.frame_end = 1'b0;
        res_ch.ready = 1'b0;
        rnd_frames = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        src_idle_pct = 33;
        snk_idle_pct = 81;

        // smallest valid frame, lower case CRC
        body.delete();
        add_text("QN=;CN=;CP=&&DataTime=&&");
        wrap_body(0);
        send_frame();

        // upper case CRC, extreme byte values, partial tag matches
        body.delete();
        add_text(QN_TAG);
        body.push_back(8'h00);
        body.push_back(8'hFF);
        add_text(";C;CN=;CP=&&DataTim;CP=&&DataTime=&&");
        wrap_body(1);
        send_frame();

        // one-byte frame
        frame_bytes.delete();
        frame_bytes.push_back("#");
        send_frame();

        // too short
        body.delete();
        add_text("QN=&&");
        wrap_body(0);
        send_frame();

        body.delete();
        add_text("QN=;CN=;CP=&&DataTime=&&");

        // bad start mark
        wrap_body(0);
        frame_bytes[1] = "$";
        send_frame();

        // no CR LF
        wrap_body(0);
        frame_bytes[frame_bytes.size() - 1] = 8'h0B;
        send_frame();

        // non-digit length characters
        wrap_body(0);
        frame_bytes[2] = 8'h00;
        frame_bytes[4] = 8'hFF;
        send_frame();

        // zero length
        wrap_body(0);
        for (int i = 2; i < 6; i++) frame_bytes[i] = "0";
        send_frame();

        // length one too large, one too small
        wrap_body(0);
        frame_bytes[5] = frame_bytes[5] + 8'd1;
        send_frame();
        wrap_body(1);
        frame_bytes[5] = frame_bytes[5] - 8'd1;
        send_frame();

        // non-hex CRC character
        wrap_body(0);
        frame_bytes[frame_bytes.size() - 4] = "g";
        send_frame();

        // CRC mismatch
        wrap_body(1);
        n = frame_bytes.size() - 3;
        frame_bytes[n] = (frame_bytes[n] == "0") ? "1" : "0";
        send_frame();

        // field failures: QN, content end, CN, CP
        body.delete();
        add_text("QX=;CN=;CP=&&DataTime=&&");
        wrap_body(0);
        send_frame();
        body.delete();
        add_text("QN=;CN=;CP=&&DataTime=&X");
        wrap_body(0);
        send_frame();
        body.delete();
        add_text("QN=;CM=;CP=&&DataTime=&&");
        wrap_body(0);
        send_frame();
        body.delete();
        add_text("QN=;CN=;CP=&&DataTimE=&&");
        wrap_body(0);
        send_frame();

        // longer frame with arbitrary fill bytes, valid
        body.delete();
        add_text(QN_TAG);
        add_fill(20, 1);
        add_text(CN_TAG);
        add_fill(20, 1);
        add_text(CP_TAG);
        add_fill(20, 1);
        add_text("&&");
        wrap_body(1);
        send_frame();

        wait_drained();

        while (sent_items < 1050 || rnd_frames < 9)
        begin
            if (rnd_frames == 3)
            begin
                wait_drained();
                src_idle_pct = 81;
                snk_idle_pct = 33;
            end
            else if (rnd_frames == 6)
            begin
                wait_drained();
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            kind = $urandom_range(0, 99);
            if (kind < 10)
            begin
                frame_bytes.delete();
                repeat ($urandom_range(1, 70)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                make_body(($urandom_range(0, 9) == 0) ? 120 : 6, $urandom_range(0, 3) == 0);
                wrap_body($urandom_range(0, 1));
                n = frame_bytes.size();
                if (kind >= 70)
                begin
                    case ($urandom_range(0, 5))
                        0: frame_bytes[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
                        1: repeat ($urandom_range(1, 4)) void'(frame_bytes.pop_back());
                        2: frame_bytes.insert($urandom_range(0, n - 1), 8'($urandom_range(0, 255)));
                        3: frame_bytes[$urandom_range(2, 5)] = 8'($urandom_range(48, 57));
                        4: frame_bytes[n - 6 + $urandom_range(0, 3)] = 8'($urandom_range(0, 255));
                        default: frame_bytes[n - 1] = 8'($urandom_range(0, 9));
                    endcase
                end
            end
            send_frame();
            rnd_frames++;
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (sb.errors == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/emfc_pkg.sv
rtl/emfc_if.sv
rtl/emfc_in_reg.sv
rtl/emfc_check_core.sv
rtl/env_monitor_frame_checker_unit.sv
tb/sv/tb.sv
